### hw/rtl/dpdd_pkg.sv
// dpdd_pkg: shared types and constants of the dual PID differential drive block.
// No dependencies; imported by dpdd_ctrl, dpdd_dp and the top level.
`default_nettype none
package dpdd_pkg;

  localparam int FIELD_W        = 32;
  localparam int GAIN_W         = 32;
  localparam int MV_W           = 16;
  localparam int DUTY_W         = 16;
  localparam int LIMIT_W        = 31;
  localparam int REG_IDX_W      = 3;
  localparam int IN_DATA_W      = 4 * FIELD_W + MV_W;
  localparam int OUT_DATA_W     = 2 * DUTY_W;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int INTEGRAL_WIDTH_DEF = 48;
  localparam int MILLI_X2       = 2000;
  localparam int DIVISOR_W      = 27;
  localparam int DIV_STEPS      = 16;
  localparam int CNT_W          = $clog2(DIV_STEPS);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd19660800;

  localparam logic [REG_IDX_W-1:0] REG_SPEED_P = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_I = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_D = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TURN_P  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TURN_I  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TURN_D  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT   = 3'd6;

  typedef enum logic [1:0] {
    RUN_OK    = 2'd0,
    RUN_OFF   = 2'd1,
    RUN_LIMIT = 2'd2,
    RUN_BATT  = 2'd3
  } run_status_e;

  typedef struct packed {
    logic                 load;
    logic                 eval;
    logic                 mul;
    logic                 first;
    logic                 last;
    logic [REG_IDX_W-1:0] prod_sel;
    logic                 mix;
    logic                 div_init;
    logic                 div_step;
    logic                 out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic stop;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_l;
    logic [DUTY_W-1:0] duty_r;
    run_status_e       status;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/dpdd_ctrl.sv
// dpdd_ctrl: sequencer of one control tick (load, evaluate, multiply, mix, divide).
// Depends on dpdd_pkg; drives dpdd_dp through cmd_t.
`default_nettype none
module dpdd_ctrl #(
  parameter int CHUNKS = 3
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dpdd_pkg::sts_t sts_i,
  output dpdd_pkg::cmd_t     cmd_o,
  output logic               in_ready_o
);
  import dpdd_pkg::*;

  localparam int KW = $clog2(CHUNKS);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EVAL  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_DRAIN = 8'b0000_1000,
    S_MIX   = 8'b0001_0000,
    S_DIVI  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [KW-1:0]        k_q, k_d;
  logic [REG_IDX_W-1:0] p_q, p_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 k_last;

  assign k_last     = (k_q == KW'(CHUNKS - 1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    p_d     = p_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (sts_i.in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        k_d        = '0;
        p_d        = REG_SPEED_P;
        state_d    = sts_i.stop ? S_FIN : S_MUL;
      end
      S_MUL: begin
        cmd_o.mul      = 1'b1;
        cmd_o.first    = (k_q == '0);
        cmd_o.last     = k_last;
        cmd_o.prod_sel = p_q;
        k_d            = k_q + 1'b1;
        if (k_last) begin
          k_d = '0;
          p_d = p_q + 1'b1;
          if (p_q == REG_TURN_D) begin
            cnt_d   = '0;
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(1)) state_d = S_MIX;
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      p_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      p_q     <= p_d;
      cnt_q   <= cnt_d;
    end
  end

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.eval, cmd_o.mul, cmd_o.mix, cmd_o.div_init,
              cmd_o.div_step, cmd_o.out_load}))
    else $error("dpdd_ctrl: overlapping commands");

  a_load_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.eval)
    else $error("dpdd_ctrl: load not followed by evaluate");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("dpdd_ctrl: result loaded into a full output register");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mix |-> (!$past(cmd_o.mul) && !$past(cmd_o.mul, 2)))
    else $error("dpdd_ctrl: mix before multiply pipeline drained");

endmodule
`default_nettype wire

### hw/rtl/dpdd_dp.sv
// dpdd_dp: datapath with loop state, chunked gain multiplier, mixer and two dividers.
// Depends on dpdd_pkg; commanded by dpdd_ctrl.
`default_nettype none
module dpdd_dp #(
  parameter int DATA_WIDTH     = dpdd_pkg::DATA_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = dpdd_pkg::INTEGRAL_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire dpdd_pkg::cmd_t                      cmd_i,
  input  wire logic                                en_i,
  input  wire logic [dpdd_pkg::IN_DATA_W-1:0]      data_i,
  input  wire logic [5:0][dpdd_pkg::GAIN_W-1:0]    gains_i,
  input  wire logic [dpdd_pkg::LIMIT_W-1:0]        limit_i,
  output logic                                     stop_o,
  output dpdd_pkg::result_t                        result_o
);
  import dpdd_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int IW  = INTEGRAL_WIDTH;
  localparam int XW  = (DW > FIELD_W + 1) ? DW : FIELD_W + 1;
  localparam int SW  = ((IW > DW) ? IW : DW) + 1;
  localparam int OMX = (IW > DW + 1) ? IW : DW + 1;
  localparam int OPW = ((OMX + 15) / 16) * 16;
  localparam int PW  = GAIN_W + OPW;
  localparam int QW  = (PW - 16 > 64) ? PW - 16 : 64;
  localparam int RW  = DIVISOR_W + 16;
  localparam int PRW = GAIN_W + 17;

  function automatic logic signed [DW-1:0] sat_err(input logic signed [XW-1:0] v);
    logic [XW-DW:0] hi;
    hi = v[XW-1:DW-1];
    if ((&hi) || !(|hi)) return v[DW-1:0];
    else if (v[XW-1]) return {1'b1, {(DW-1){1'b0}}};
    else return {1'b0, {(DW-1){1'b1}}};
  endfunction

  function automatic logic signed [IW-1:0] sat_int(input logic signed [SW-1:0] v);
    logic [SW-IW:0] hi;
    hi = v[SW-1:IW-1];
    if ((&hi) || !(|hi)) return v[IW-1:0];
    else if (v[SW-1]) return {1'b1, {(IW-1){1'b0}}};
    else return {1'b0, {(IW-1){1'b1}}};
  endfunction

  function automatic logic signed [63:0] sat_q64(input logic signed [QW-1:0] v);
    logic [QW-64:0] hi;
    hi = v[QW-1:63];
    if ((&hi) || !(|hi)) return v[63:0];
    else if (v[QW-1]) return {1'b1, 63'd0};
    else return {1'b0, {63{1'b1}}};
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else return s[63:0];
  endfunction

  function automatic logic signed [63:0] neg_sat64(input logic signed [63:0] a);
    if (a == {1'b1, 63'd0}) return {1'b0, {63{1'b1}}};
    else return -a;
  endfunction

  function automatic logic [DUTY_W-1:0] to_duty(input logic neg, input logic sat,
                                                input logic [15:0] q);
    logic big;
    big = sat | q[15];
    if (neg) return big ? 16'h8000 : (16'd0 - q);
    else return big ? 16'h7fff : q;
  endfunction

  // input word
  logic                       en_q;
  logic signed [FIELD_W-1:0]  ts_q, tt_q, ms_q, mt_q;
  logic [MV_W-1:0]            mv_q;
  // loop state
  logic                       loop_en_q;
  logic signed [IW-1:0]       si_q, ti_q;
  logic signed [DW-1:0]       pse_q, pte_q;
  // work registers
  logic signed [DW-1:0]       es_q, et_q;
  logic signed [DW:0]         ds_q, dt_q;
  logic signed [63:0]         cs_q, ct_q, numl_q, numr_q;
  logic [DIVISOR_W-1:0]       dvs_q;
  run_status_e                status_q;
  logic [OPW-1:0]             sh_q;
  logic signed [PRW-1:0]      prod_q;
  logic                       m_vld_q, m_first_q, m_last_q, m_ct_q;
  logic signed [PW-1:0]       acc_q;
  logic                       a_vld_q, a_ct_q;
  logic [RW-1:0]              reml_q, remr_q, dsh_q;
  logic [15:0]                ql_q, qr_q;
  logic                       negl_q, negr_q, satl_q, satr_q;

  // evaluation
  logic                       clr;
  logic signed [IW-1:0]       si_eff, ti_eff, si_new, ti_new;
  logic signed [FIELD_W:0]    es_raw, et_raw;
  logic signed [DW-1:0]       es_w, et_w;
  run_status_e                status_w;

  assign clr    = !loop_en_q;
  assign si_eff = clr ? '0 : si_q;
  assign ti_eff = clr ? '0 : ti_q;
  assign es_raw = (FIELD_W + 1)'(ts_q) - (FIELD_W + 1)'(ms_q);
  assign et_raw = (FIELD_W + 1)'(tt_q) - (FIELD_W + 1)'(mt_q);
  assign es_w   = sat_err(XW'(es_raw));
  assign et_w   = sat_err(XW'(et_raw));
  assign si_new = sat_int(SW'(si_eff) + SW'(es_w));
  assign ti_new = sat_int(SW'(ti_eff) + SW'(et_w));

  always_comb begin
    if (!en_q) status_w = RUN_OFF;
    else if (ti_eff > IW'($signed({1'b0, limit_i}))) status_w = RUN_LIMIT;
    else if (mv_q == '0) status_w = RUN_BATT;
    else status_w = RUN_OK;
  end
  assign stop_o = (status_w != RUN_OK);

  // multiplier operand and gain
  logic signed [OPW-1:0]    opnd;
  logic signed [GAIN_W-1:0] gain;
  logic [OPW-1:0]           src;
  logic [15:0]              chunk_hi;
  logic signed [16:0]       chunk;
  logic signed [PRW-1:0]    prod_d;

  always_comb begin
    unique case (cmd_i.prod_sel)
      REG_SPEED_P: begin opnd = OPW'(es_q); gain = gains_i[0]; end
      REG_SPEED_I: begin opnd = OPW'(si_q); gain = gains_i[1]; end
      REG_SPEED_D: begin opnd = OPW'(ds_q); gain = gains_i[2]; end
      REG_TURN_P:  begin opnd = OPW'(et_q); gain = gains_i[3]; end
      REG_TURN_I:  begin opnd = OPW'(ti_q); gain = gains_i[4]; end
      REG_TURN_D:  begin opnd = OPW'(dt_q); gain = gains_i[5]; end
      default:     begin opnd = '0;         gain = '0;         end
    endcase
  end

  assign src      = cmd_i.first ? opnd : sh_q;
  assign chunk_hi = src[OPW-1 -: 16];
  assign chunk    = cmd_i.first ? {chunk_hi[15], chunk_hi} : {1'b0, chunk_hi};
  assign prod_d   = PRW'(gain) * PRW'(chunk);

  logic signed [63:0] term;
  logic signed [PW-17:0] acc_sh;
  assign acc_sh = acc_q[PW-1:16];
  assign term   = sat_q64(QW'(acc_sh));

  // divider setup
  logic [63:0]          magl, magr, dlim;
  logic [DIVISOR_W-1:0] dvs_d;
  assign magl  = numl_q[63] ? (64'd0 - $unsigned(numl_q)) : $unsigned(numl_q);
  assign magr  = numr_q[63] ? (64'd0 - $unsigned(numr_q)) : $unsigned(numr_q);
  assign dlim  = 64'({dvs_q, 16'd0});
  assign dvs_d = DIVISOR_W'(mv_q) * DIVISOR_W'(MILLI_X2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_en_q <= 1'b0;
      si_q      <= '0;
      ti_q      <= '0;
      pse_q     <= '0;
      pte_q     <= '0;
      m_vld_q   <= 1'b0;
      a_vld_q   <= 1'b0;
    end else begin
      m_vld_q <= cmd_i.mul;
      a_vld_q <= m_vld_q && m_last_q;
      if (cmd_i.eval) begin
        unique case (status_w)
          RUN_OFF: loop_en_q <= 1'b0;
          RUN_LIMIT, RUN_BATT: begin
            loop_en_q <= 1'b0;
            si_q      <= si_eff;
            ti_q      <= ti_eff;
          end
          RUN_OK: begin
            loop_en_q <= 1'b1;
            si_q      <= si_new;
            ti_q      <= ti_new;
            pse_q     <= es_w;
            pte_q     <= et_w;
          end
          default: loop_en_q <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      en_q <= en_i;
      ts_q <= data_i[FIELD_W-1:0];
      tt_q <= data_i[2*FIELD_W-1:FIELD_W];
      ms_q <= data_i[3*FIELD_W-1:2*FIELD_W];
      mt_q <= data_i[4*FIELD_W-1:3*FIELD_W];
      mv_q <= data_i[IN_DATA_W-1:4*FIELD_W];
    end
    if (cmd_i.eval) begin
      status_q <= status_w;
      es_q     <= es_w;
      et_q     <= et_w;
      ds_q     <= (DW + 1)'(es_w) - (DW + 1)'(pse_q);
      dt_q     <= (DW + 1)'(et_w) - (DW + 1)'(pte_q);
      dvs_q    <= dvs_d;
      cs_q     <= '0;
      ct_q     <= '0;
    end
    if (cmd_i.mul) begin
      sh_q      <= src << 16;
      prod_q    <= prod_d;
      m_first_q <= cmd_i.first;
      m_last_q  <= cmd_i.last;
      m_ct_q    <= (cmd_i.prod_sel >= REG_TURN_P);
    end
    if (m_vld_q) begin
      acc_q  <= m_first_q ? PW'(prod_q) : (acc_q <<< 16) + PW'(prod_q);
      a_ct_q <= m_ct_q;
    end
    if (a_vld_q) begin
      if (a_ct_q) ct_q <= sat_add64(ct_q, term);
      else cs_q <= sat_add64(cs_q, term);
    end
    if (cmd_i.mix) begin
      numl_q <= sat_add64(cs_q, neg_sat64(ct_q));
      numr_q <= sat_add64(cs_q, ct_q);
    end
    if (cmd_i.div_init) begin
      negl_q <= numl_q[63];
      negr_q <= numr_q[63];
      satl_q <= (magl >= dlim);
      satr_q <= (magr >= dlim);
      reml_q <= magl[RW-1:0];
      remr_q <= magr[RW-1:0];
      dsh_q  <= RW'({dvs_q, 15'd0});
      ql_q   <= '0;
      qr_q   <= '0;
    end
    if (cmd_i.div_step) begin
      dsh_q <= dsh_q >> 1;
      if (reml_q >= dsh_q) begin
        reml_q <= reml_q - dsh_q;
        ql_q   <= {ql_q[14:0], 1'b1};
      end else begin
        ql_q <= {ql_q[14:0], 1'b0};
      end
      if (remr_q >= dsh_q) begin
        remr_q <= remr_q - dsh_q;
        qr_q   <= {qr_q[14:0], 1'b1};
      end else begin
        qr_q <= {qr_q[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    result_o.status = status_q;
    if (status_q == RUN_OK) begin
      result_o.duty_l = to_duty(negl_q, satl_q, ql_q);
      result_o.duty_r = to_duty(negr_q, satr_q, qr_q);
    end else begin
      result_o.duty_l = '0;
      result_o.duty_r = '0;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/dual_pid_differential_drive_top.sv
// Each running word passes through the shared 32x17 multiplier, which takes its
// operands in chunks of 16 bits (3 by default), and through the one-bit-per-cycle
// dividers; a stopped word skips both. One word in flight; next word accepted the
// cycle after the result enters the output register.
// Reset (async, active low) clears control, loop state, configuration and output valid.
`default_nettype none
module dual_pid_differential_drive_top #(
  parameter int DATA_WIDTH     = dpdd_pkg::DATA_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = dpdd_pkg::INTEGRAL_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // target_speed, target_turn_rate, measured_speed, measured_turn_rate, battery_millivolts
  input  wire logic [dpdd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // command_enable
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // duty_left, duty_right
  output logic [dpdd_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // run_status
  output logic [1:0]                              m_axis_tuser,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [dpdd_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [dpdd_pkg::GAIN_W-1:0]        cfg_data_i
);
  import dpdd_pkg::*;

  localparam int OMX    = (INTEGRAL_WIDTH > DATA_WIDTH + 1) ? INTEGRAL_WIDTH : DATA_WIDTH + 1;
  localparam int CHUNKS = (OMX + 15) / 16;

  logic [5:0][GAIN_W-1:0] gains_q;
  logic [LIMIT_W-1:0]     limit_q;
  cmd_t                   cmd;
  sts_t                   sts;
  result_t                res;
  logic                   stop;
  logic                   out_vld_q;
  logic [OUT_DATA_W-1:0]  out_data_q;
  logic [1:0]             out_user_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SPEED_P: gains_q[0] <= cfg_data_i;
        REG_SPEED_I: gains_q[1] <= cfg_data_i;
        REG_SPEED_D: gains_q[2] <= cfg_data_i;
        REG_TURN_P:  gains_q[3] <= cfg_data_i;
        REG_TURN_I:  gains_q[4] <= cfg_data_i;
        REG_TURN_D:  gains_q[5] <= cfg_data_i;
        REG_LIMIT:   limit_q    <= cfg_data_i[LIMIT_W-1:0];
        default:     limit_q    <= limit_q;
      endcase
    end
  end

  assign sts.in_valid = s_axis_tvalid;
  assign sts.stop     = stop;
  assign sts.out_free = !out_vld_q || m_axis_tready;

  dpdd_ctrl #(
    .CHUNKS (CHUNKS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  dpdd_dp #(
    .DATA_WIDTH     (DATA_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .en_i     (s_axis_tuser),
    .data_i   (s_axis_tdata),
    .gains_i  (gains_q),
    .limit_i  (limit_q),
    .stop_o   (stop),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_data_q <= {res.duty_r, res.duty_l};
      out_user_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for dual_pid_differential_drive_top: drives control ticks and
// register writes, predicts duty and run status per tick, compares every output word.
// Depends on dpdd_pkg and the top-level RTL only.
`default_nettype none

class duty_scoreboard;
  logic [31:0] gain [0:5];
  logic [30:0] turn_limit;
  bit          loop_on;
  longint      speed_acc, turn_acc, prev_speed_err, prev_turn_err;
  logic [15:0] want_left [$];
  logic [15:0] want_right [$];
  logic [1:0]  want_status [$];
  int          errors, checked;

  function new();
    for (int k = 0; k < 6; k++) gain[k] = '0;
    turn_limit = dpdd_pkg::LIMIT_RESET;
    loop_on = 0;
    speed_acc = 0; turn_acc = 0; prev_speed_err = 0; prev_turn_err = 0;
    errors = 0; checked = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    if (idx == dpdd_pkg::REG_LIMIT) turn_limit = val[30:0];
    else if (idx < dpdd_pkg::REG_LIMIT) gain[idx] = val;
  endfunction

  static function longint add_sat(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(signed'(a)) + 65'(signed'(b));
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s);
  endfunction

  static function longint clamp_to(longint x, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  static function longint q16_product(logic signed [31:0] g, longint v);
    logic signed [127:0] p;
    p = 128'(g) * 128'(v);
    p = p >>> 16;
    if (p > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (p < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(p);
  endfunction

  function longint loop_out(int base, longint e, longint i, longint d);
    longint s;
    s = q16_product(gain[base], e);
    s = add_sat(s, q16_product(gain[base + 1], i));
    return add_sat(s, q16_product(gain[base + 2], d));
  endfunction

  static function logic [15:0] duty_of(longint num, logic [15:0] mv);
    logic [63:0] mag, q;
    mag = num < 0 ? 64'(0) - 64'(num) : 64'(num);
    q = mag / (64'd2000 * 64'(mv));
    if (num < 0) return q > 64'd32768 ? 16'h8000 : 16'(-q);
    return q > 64'd32767 ? 16'h7FFF : 16'(q);
  endfunction

  function void stop_tick(logic [1:0] st);
    loop_on = 0;
    want_left.push_back('0); want_right.push_back('0); want_status.push_back(st);
  endfunction

  function void note_tick(logic en, logic signed [31:0] ts, logic signed [31:0] tt,
                          logic signed [31:0] ms, logic signed [31:0] mt,
                          logic [15:0] mv);
    longint es, et, ds, dt, cs, ct;
    if (!en) begin
      stop_tick(dpdd_pkg::RUN_OFF);
      return;
    end
    if (!loop_on) begin
      loop_on = 1; speed_acc = 0; turn_acc = 0;
    end
    if (turn_acc > longint'(turn_limit)) begin
      stop_tick(dpdd_pkg::RUN_LIMIT);
      return;
    end
    if (mv == 0) begin
      stop_tick(dpdd_pkg::RUN_BATT);
      return;
    end
    es = clamp_to(longint'(ts) - longint'(ms), 32);
    speed_acc = clamp_to(add_sat(speed_acc, es), 48);
    ds = es - prev_speed_err; prev_speed_err = es;
    cs = loop_out(0, es, speed_acc, ds);
    et = clamp_to(longint'(tt) - longint'(mt), 32);
    turn_acc = clamp_to(add_sat(turn_acc, et), 48);
    dt = et - prev_turn_err; prev_turn_err = et;
    ct = loop_out(3, et, turn_acc, dt);
    want_left.push_back(duty_of(add_sat(cs, ct == 64'sh8000_0000_0000_0000 ?
                                        64'sh7FFF_FFFF_FFFF_FFFF : -ct), mv));
    want_right.push_back(duty_of(add_sat(cs, ct), mv));
    want_status.push_back(dpdd_pkg::RUN_OK);
  endfunction

  function void check_word(logic [31:0] data, logic [1:0] st);
    logic [15:0] l, r;
    logic [1:0]  s;
    if (want_status.size() == 0) begin
      $display("%0t: unexpected word, actual duty %h status %0d", $time, data, st);
      errors++;
      return;
    end
    l = want_left.pop_front(); r = want_right.pop_front(); s = want_status.pop_front();
    checked++;
    if (data[15:0] !== l) begin
      $display("%0t: duty_left expected %h actual %h", $time, l, data[15:0]);
      errors++;
    end
    if (data[31:16] !== r) begin
      $display("%0t: duty_right expected %h actual %h", $time, r, data[31:16]);
      errors++;
    end
    if (st !== s) begin
      $display("%0t: run_status expected %0d actual %0d", $time, s, st);
      errors++;
    end
  endfunction

  function int pending();
    return want_status.size();
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dpdd_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready, s_axis_tuser = 0;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i = 0, cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [GAIN_W-1:0] cfg_data_i = '0;

  duty_scoreboard board = new();
  int send_idle_pct = 0, recv_stall_pct = 0, tick_count = 0;
  longint cycle_count = 0;

  dual_pid_differential_drive_top dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAIL dual_pid_differential_drive_top");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata, m_axis_tuser);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, val);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_tick(logic en, logic [31:0] ts, logic [31:0] tt,
                           logic [31:0] ms, logic [31:0] mt, logic [15:0] mv);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1; s_axis_tuser <= en;
    s_axis_tdata <= {mv, mt, ms, tt, ts};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_tick(en, ts, tt, ms, mt, mv);
    tick_count++;
    s_axis_tvalid <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_val();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(3);
      2: return 32'h7FFF_FFFF - $urandom_range(3);
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain(int mode);
    case (mode)
      0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return $urandom;
      default: return 32'($signed($urandom_range(20000)) - 10000);
    endcase
  endfunction

  task automatic random_ticks(int n);
    logic [15:0] mv;
    for (int k = 0; k < n; k++) begin
      mv = $urandom_range(9) == 0 ? 16'd0 :
           ($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(12000, 6000)));
      send_tick($urandom_range(11) != 0, pick_val(), pick_val(), pick_val(), pick_val(), mv);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: default gains, then fixed gains with extreme inputs and special cases
    send_tick(0, '0, '0, '0, '0, 16'd8000);
    send_tick(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    drain();
    write_reg(REG_SPEED_P, 32'h0001_0000); write_reg(REG_SPEED_I, 32'h0000_1000);
    write_reg(REG_SPEED_D, 32'h0000_8000); write_reg(REG_TURN_P, 32'h0002_0000);
    write_reg(REG_TURN_I, 32'h0000_2000);  write_reg(REG_TURN_D, 32'hFFFF_0000);
    write_reg(REG_LIMIT, 32'd19660800);
    write_reg(3'd7, 32'hFFFF_FFFF);
    send_tick(1, 32'h0010_0000, 32'h0005_0000, '0, '0, 16'd8000);
    send_tick(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'd1);
    send_tick(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd1);
    send_tick(1, '0, '0, '0, '0, 16'd0);
    send_tick(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'd5000);
    send_tick(1, '0, '0, '0, '0, 16'd5000);
    send_tick(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_tick(1, 32'h0001_0000, 32'hFFFF_0000, '0, '0, 16'd7400);
    drain();
    write_reg(REG_LIMIT, '0);
    send_tick(1, '0, 32'h0000_0001, '0, '0, 16'd7400);
    send_tick(1, '0, '0, '0, '0, 16'd7400);
    drain();
    write_reg(REG_LIMIT, 32'h7FFF_FFFF);
    // random phases with varied gains and idling
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      for (int r = 0; r < 6; r++) write_reg(3'(r), pick_gain(ph % 3));
      write_reg(REG_LIMIT, ph % 4 == 0 ? 32'h7FFF_FFFF :
                           (ph % 4 == 1 ? 32'd0 : 32'($urandom_range(40000000))));
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 87; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 87; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      random_ticks(62);
    end
    drain();
    $display("Ran %0d control ticks over 12 gain/limit settings and four idling mixes,",
             tick_count);
    $display("%0d output words compared.", board.checked);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS dual_pid_differential_drive_top");
    end else begin
      $display("FAIL dual_pid_differential_drive_top");
    end
    $finish;
  end
endmodule
`default_nettype wire
